>>> rtl/core/mlfq_pkg.sv
// Shared types and constants of the multilevel feedback queue scheduler.
`timescale 1ns / 1ps
package mlfq_pkg;

  localparam int ID_BITS          = 8;
  localparam int TIME_BITS        = 16;
  localparam int MODE_W           = 2;
  localparam int NUM_LEVELS_W     = 3;
  localparam int RUN_LEVEL_W      = 3;
  localparam int MAX_LEVELS_DEF   = 8;
  localparam int LEVEL_DEPTH_DEF  = 16;

  localparam logic [NUM_LEVELS_W-1:0] NUM_LEVELS_RST = 3'd3;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SELECT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CHECK  = 2'd2;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_SELECT,
    OP_CHECK,
    OP_NOP
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } be_state_e;

  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic                 new_process;
    logic [ID_BITS-1:0]   task_id;
    logic [TIME_BITS-1:0] service_total;
    logic [TIME_BITS-1:0] service_done;
    logic [TIME_BITS-1:0] elapsed_ticks;
  } in_word_t;

  typedef struct packed {
    logic                   granted;
    logic [ID_BITS-1:0]     out_task_id;
    logic [TIME_BITS-1:0]   out_service_total;
    logic [TIME_BITS-1:0]   out_service_done;
    logic                   keep_running;
    logic [RUN_LEVEL_W-1:0] run_level;
    logic                   queue_error;
    logic                   none_waiting;
  } out_word_t;

  typedef struct packed {
    logic [ID_BITS-1:0]   task_id;
    logic [TIME_BITS-1:0] service_total;
    logic [TIME_BITS-1:0] service_done;
  } entry_t;

  typedef struct packed {
    op_e                  op;
    logic                 is_new;
    logic [ID_BITS-1:0]   task_id;
    logic [TIME_BITS-1:0] service_total;
    logic [TIME_BITS-1:0] service_done;
    logic [TIME_BITS-1:0] elapsed_ticks;
    logic                 finished;
  } cmd_t;

endpackage

>>> rtl/core/multilevel_feedback_scheduler.sv
// Top level of the multilevel feedback queue scheduler.
`timescale 1ns / 1ps
// Multilevel feedback queue scheduler. The front end takes one input word per
// cycle while it has room into a two-entry command queue; the back end runs one
// command at a time and presents one result word per command through an output
// register. A select that finds a task also passes a read state, as the task
// store is a RAM with registered read. The store is never cleared; level pointers
// and fill counts reset to zero, so no clearing pass is needed. num_levels is
// written via cfg_valid_i/cfg_data_i; only while idle, which the user must ensure.
module multilevel_feedback_scheduler #(
  parameter int MAX_LEVELS  = mlfq_pkg::MAX_LEVELS_DEF,
  parameter int LEVEL_DEPTH = mlfq_pkg::LEVEL_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  mlfq_pkg::in_word_t                in_word_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output mlfq_pkg::out_word_t               out_word_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mlfq_pkg::NUM_LEVELS_W-1:0] cfg_data_i
);
  import mlfq_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  mlfq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  mlfq_back #(
    .MAX_LEVELS  (MAX_LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

>>> rtl/core/mlfq_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module mlfq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/mlfq_front.sv
// Front end: accepts input words, decodes them and buffers commands in a two-entry queue.
`timescale 1ns / 1ps
module mlfq_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mlfq_pkg::in_word_t in_word_i,
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i,
  output mlfq_pkg::cmd_t     cmd_o
);
  import mlfq_pkg::*;

  cmd_t        cmd_new;
  cmd_t        slot_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        push, pop;

  always_comb begin
    cmd_new.is_new        = in_word_i.new_process;
    cmd_new.task_id       = in_word_i.task_id;
    cmd_new.service_total = in_word_i.service_total;
    cmd_new.service_done  = in_word_i.service_done;
    cmd_new.elapsed_ticks = in_word_i.elapsed_ticks;
    // finished when done + elapsed reaches total, full-width sum
    cmd_new.finished = ({1'b0, in_word_i.service_done} + {1'b0, in_word_i.elapsed_ticks})
                       >= {1'b0, in_word_i.service_total};
    unique case (in_word_i.mode)
      MODE_INSERT: cmd_new.op = OP_INSERT;
      MODE_SELECT: cmd_new.op = OP_SELECT;
      MODE_CHECK:  cmd_new.op = OP_CHECK;
      default:     cmd_new.op = OP_NOP;
    endcase
  end

  assign in_ready_o  = (count_q != 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

>>> rtl/core/mlfq_back.sv
// Back end: level bookkeeping, task store, run decisions and the output register.
`timescale 1ns / 1ps
module mlfq_back #(
  parameter int MAX_LEVELS  = mlfq_pkg::MAX_LEVELS_DEF,
  parameter int LEVEL_DEPTH = mlfq_pkg::LEVEL_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [mlfq_pkg::NUM_LEVELS_W-1:0] cfg_data_i,
  input  logic                              cmd_valid_i,
  output logic                              cmd_ready_o,
  input  mlfq_pkg::cmd_t                    cmd_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output mlfq_pkg::out_word_t               out_word_o
);
  import mlfq_pkg::*;

  localparam int LVL_W     = $clog2(MAX_LEVELS);
  localparam int PTR_W     = $clog2(LEVEL_DEPTH);
  localparam int FILL_W    = $clog2(LEVEL_DEPTH + 1);
  localparam int RAM_DEPTH = MAX_LEVELS * LEVEL_DEPTH;
  localparam int ADDR_W    = $clog2(RAM_DEPTH);
  localparam int CNT_W     = $clog2(RAM_DEPTH + 1);
  localparam int ENTRY_W   = $bits(entry_t);

  be_state_e               state_q, state_d;
  logic [NUM_LEVELS_W-1:0] num_levels_q;
  logic [PTR_W-1:0]        head_q [MAX_LEVELS];
  logic [PTR_W-1:0]        tail_q [MAX_LEVELS];
  logic [FILL_W-1:0]       fill_q [MAX_LEVELS];
  logic [LVL_W-1:0]        cur_lvl_q, cur_lvl_d;
  logic                    has_cur_q, has_cur_d;
  logic [CNT_W-1:0]        wait_cnt_q, wait_cnt_d;
  logic                    out_valid_q, out_valid_d;
  out_word_t               out_word_q, out_word_d;

  logic [LVL_W-1:0]  last_lvl;
  logic [LVL_W-1:0]  scan_lvl;
  logic              found;
  logic              refuse;
  logic [LVL_W-1:0]  ins_lvl;
  logic [LVL_W-1:0]  tgt_lvl;
  logic              ins_ok;
  logic [PTR_W-1:0]  ptr;
  logic [PTR_W-1:0]  ptr_inc;
  logic [ADDR_W-1:0] addr;
  logic              keep;
  logic              do_ins, do_sel;
  logic              out_free;
  entry_t            wr_entry;
  entry_t            rd_entry;
  logic [ENTRY_W-1:0] rdata;

  always_comb begin
    if (num_levels_q > NUM_LEVELS_W'(MAX_LEVELS - 1)) begin
      last_lvl = LVL_W'(MAX_LEVELS - 1);
    end else begin
      last_lvl = num_levels_q[LVL_W-1:0];
    end
  end

  // highest-priority non-empty level within range
  always_comb begin
    found    = 1'b0;
    scan_lvl = '0;
    for (int l = MAX_LEVELS - 1; l >= 0; l--) begin
      if (LVL_W'(l) <= last_lvl && fill_q[l] != '0) begin
        found    = 1'b1;
        scan_lvl = LVL_W'(l);
      end
    end
  end

  always_comb begin
    refuse  = !cmd_i.is_new && has_cur_q && (cur_lvl_q >= last_lvl);
    ins_lvl = (cmd_i.is_new || !has_cur_q || refuse) ? '0 : cur_lvl_q + 1'b1;
    tgt_lvl = (cmd_i.op == OP_SELECT) ? scan_lvl : ins_lvl;
    ins_ok  = !refuse && (fill_q[tgt_lvl] != FILL_W'(LEVEL_DEPTH));
    ptr     = (cmd_i.op == OP_SELECT) ? head_q[tgt_lvl] : tail_q[tgt_lvl];
    ptr_inc = (ptr == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : ptr + 1'b1;
    addr    = ADDR_W'(tgt_lvl) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(ptr);
    keep    = has_cur_q && !cmd_i.finished &&
              ((cur_lvl_q >= last_lvl) || ((cmd_i.elapsed_ticks >> cur_lvl_q) == '0));
  end

  assign wr_entry.task_id       = cmd_i.task_id;
  assign wr_entry.service_total = cmd_i.service_total;
  assign wr_entry.service_done  = cmd_i.service_done;
  assign rd_entry               = entry_t'(rdata);

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    cur_lvl_d   = cur_lvl_q;
    has_cur_d   = has_cur_q;
    wait_cnt_d  = wait_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_word_d  = out_word_q;
    cmd_ready_o = 1'b0;
    do_ins      = 1'b0;
    do_sel      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_ready_o = out_free;
        if (cmd_valid_i && out_free) begin
          out_word_d = '0;
          case (cmd_i.op)
            OP_INSERT: begin
              do_ins = ins_ok;
              if (ins_ok) begin
                wait_cnt_d = wait_cnt_q + 1'b1;
              end
              out_word_d.granted     = ins_ok;
              out_word_d.queue_error = !ins_ok;
            end
            OP_SELECT: begin
              if (found) begin
                do_sel     = 1'b1;
                cur_lvl_d  = scan_lvl;
                has_cur_d  = 1'b1;
                wait_cnt_d = wait_cnt_q - 1'b1;
                state_d    = ST_READ;
              end
            end
            OP_CHECK: begin
              out_word_d.keep_running = keep;
            end
            default: begin
            end
          endcase
          out_word_d.run_level    = RUN_LEVEL_W'(cur_lvl_d);
          out_word_d.none_waiting = (wait_cnt_d == '0);
          out_valid_d             = !(cmd_i.op == OP_SELECT && found);
        end
      end
      ST_READ: begin
        out_valid_d                  = 1'b1;
        out_word_d                   = '0;
        out_word_d.granted           = 1'b1;
        out_word_d.out_task_id       = rd_entry.task_id;
        out_word_d.out_service_total = rd_entry.service_total;
        out_word_d.out_service_done  = rd_entry.service_done;
        out_word_d.run_level         = RUN_LEVEL_W'(cur_lvl_q);
        out_word_d.none_waiting      = (wait_cnt_q == '0);
        state_d                      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      num_levels_q <= NUM_LEVELS_RST;
      cur_lvl_q    <= '0;
      has_cur_q    <= 1'b0;
      wait_cnt_q   <= '0;
      out_valid_q  <= 1'b0;
      for (int l = 0; l < MAX_LEVELS; l++) begin
        head_q[l] <= '0;
        tail_q[l] <= '0;
        fill_q[l] <= '0;
      end
    end else begin
      state_q     <= state_d;
      cur_lvl_q   <= cur_lvl_d;
      has_cur_q   <= has_cur_d;
      wait_cnt_q  <= wait_cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        num_levels_q <= cfg_data_i;
      end
      if (do_ins) begin
        tail_q[tgt_lvl] <= ptr_inc;
        fill_q[tgt_lvl] <= fill_q[tgt_lvl] + 1'b1;
      end
      if (do_sel) begin
        head_q[tgt_lvl] <= ptr_inc;
        fill_q[tgt_lvl] <= fill_q[tgt_lvl] - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  mlfq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (do_ins),
    .waddr_i (addr),
    .wdata_i (wr_entry),
    .re_i    (do_sel),
    .raddr_i (addr),
    .rdata_o (rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

>>> verif/multilevel_feedback_scheduler_tb.sv
// Self-checking testbench of the multilevel feedback queue scheduler.
`timescale 1ns / 1ps
module multilevel_feedback_scheduler_tb;
  import mlfq_pkg::*;

  localparam int MaxLv = MAX_LEVELS_DEF;
  localparam int Depth = LEVEL_DEPTH_DEF;

  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t res;
  } dir_row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready_o;
  in_word_t                in_word = '0;
  logic                    out_valid_o;
  logic                    out_ready = 1'b0;
  out_word_t               out_word_o;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready_o;
  logic [NUM_LEVELS_W-1:0] cfg_data = '0;

  // scheduler mirror
  entry_t                  lvl_store [MaxLv][Depth];
  int                      lvl_head [MaxLv] = '{default: 0};
  int                      lvl_tail [MaxLv] = '{default: 0};
  int                      lvl_fill [MaxLv] = '{default: 0};
  logic [2:0]              cur_lvl = '0;
  bit                      has_cur = 1'b0;
  int                      n_waiting = 0;
  logic [NUM_LEVELS_W-1:0] lv_cfg = NUM_LEVELS_RST;
  entry_t                  running_task = '0;

  out_word_t pending_results[$];
  dir_row_t  dir_rows[$];
  int        err_cnt = 0;
  int        send_idle_pct = 10;
  int        recv_stall_pct = 66;
  int        hold_req = 0;
  int        hold_ack = 0;
  int        burst_left = 0;
  bit        burst_new = 1'b0;

  multilevel_feedback_scheduler i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic in_word_t mk_word(op_e op, bit np, logic [7:0] id, logic [15:0] tot,
                                       logic [15:0] dn, logic [15:0] el);
    in_word_t w;
    w.mode          = op;
    w.new_process   = np;
    w.task_id       = id;
    w.service_total = tot;
    w.service_done  = dn;
    w.elapsed_ticks = el;
    return w;
  endfunction

  function automatic out_word_t mk_res(bit g, logic [7:0] id, logic [15:0] tot,
                                       logic [15:0] dn, bit keep, logic [2:0] lvl,
                                       bit qerr, bit nw);
    out_word_t r;
    r.granted           = g;
    r.out_task_id       = id;
    r.out_service_total = tot;
    r.out_service_done  = dn;
    r.keep_running      = keep;
    r.run_level         = lvl;
    r.queue_error       = qerr;
    r.none_waiting      = nw;
    return r;
  endfunction

  function automatic void add_row(in_word_t w, bit typed, out_word_t res);
    dir_row_t row;
    row.w     = w;
    row.typed = typed;
    row.res   = res;
    dir_rows.insert(dir_rows.size(), row);
  endfunction

  // advances the mirror by one word and returns the result it must produce
  function automatic out_word_t sched_step(input in_word_t w);
    out_word_t   r;
    logic [2:0]  last;
    logic [3:0]  tgt;
    logic [16:0] sum;
    r    = '0;
    last = lv_cfg;
    case (op_e'(w.mode))
      OP_INSERT: begin
        if (w.new_process || !has_cur) tgt = 4'd0;
        else if (cur_lvl >= last) tgt = 4'(MaxLv);
        else tgt = {1'b0, cur_lvl} + 4'd1;
        if (tgt < MaxLv && lvl_fill[tgt] < Depth) begin
          lvl_store[tgt][lvl_tail[tgt]] = '{w.task_id, w.service_total, w.service_done};
          lvl_tail[tgt] = (lvl_tail[tgt] + 1) % Depth;
          lvl_fill[tgt]++;
          n_waiting++;
          r.granted = 1'b1;
        end else begin
          r.queue_error = 1'b1;
        end
      end
      OP_SELECT: begin
        for (int l = 0; l <= last; l++) begin
          if (lvl_fill[l] != 0) begin
            running_task        = lvl_store[l][lvl_head[l]];
            r.out_task_id       = running_task.task_id;
            r.out_service_total = running_task.service_total;
            r.out_service_done  = running_task.service_done;
            lvl_head[l] = (lvl_head[l] + 1) % Depth;
            lvl_fill[l]--;
            n_waiting--;
            cur_lvl   = 3'(l);
            has_cur   = 1'b1;
            r.granted = 1'b1;
            break;
          end
        end
      end
      OP_CHECK: begin
        if (has_cur) begin
          sum = {1'b0, w.service_done} + w.elapsed_ticks;
          if (sum >= w.service_total) r.keep_running = 1'b0;
          else if (cur_lvl >= last) r.keep_running = 1'b1;
          else r.keep_running = ({1'b0, w.elapsed_ticks} < (17'd1 << cur_lvl));
        end
      end
      default: ;
    endcase
    r.run_level    = cur_lvl;
    r.none_waiting = (n_waiting == 0);
    return r;
  endfunction

  // mostly well-formed traffic around the running task, some bursts and noise
  function automatic in_word_t next_sched_word();
    in_word_t    w;
    int unsigned pick;
    int unsigned rem;
    w = mk_word(OP_INSERT, 1'($urandom_range(0, 1)), 8'($urandom),
                16'($urandom_range(1, 65535)), 16'($urandom), 16'($urandom));
    if (burst_left == 0 && $urandom_range(0, 99) < 3) begin
      burst_left = $urandom_range(10, 20);
      burst_new  = 1'($urandom_range(0, 1));
    end
    if (burst_left > 0) begin
      burst_left--;
      w.new_process = burst_new;
      if (!burst_new && has_cur) begin
        w.service_total = running_task.service_total;
        w.service_done  = running_task.service_done;
      end
      return w;
    end
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      w.mode = 2'($urandom_range(0, 3));
    end else if (pick < 36) begin
      w.new_process = 1'b1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: w.service_total = 16'($urandom_range(1, 16));
        5, 6, 7:       w.service_total = 16'($urandom_range(1, 65535));
        default:       w.service_total = 16'hffff;
      endcase
      w.service_done = ($urandom_range(0, 9) < 7) ? 16'd0 :
                       16'($urandom_range(0, w.service_total));
    end else if (pick < 61) begin
      w.mode = OP_SELECT;
    end else if (pick < 86) begin
      w.mode = OP_CHECK;
      if (has_cur) begin
        w.task_id       = running_task.task_id;
        w.service_total = running_task.service_total;
        w.service_done  = running_task.service_done;
        rem = (w.service_total > w.service_done) ? w.service_total - w.service_done : 0;
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: w.elapsed_ticks = 16'($urandom_range(0, (1 << cur_lvl) + 1));
          6, 7: w.elapsed_ticks = (rem == 0) ? 16'd0 : 16'(rem - $urandom_range(0, 1));
          default: ;
        endcase
      end
    end else begin
      w.new_process = 1'b0;
      if (has_cur) begin
        w.task_id       = running_task.task_id;
        w.service_total = running_task.service_total;
        rem = running_task.service_done + (1 << cur_lvl);
        w.service_done  = (rem > 65535) ? 16'hffff : 16'(rem);
      end
    end
    return w;
  endfunction

  task automatic push_word(input in_word_t w, input bit typed, input out_word_t res);
    out_word_t r;
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    r = sched_step(w);
    pending_results.insert(pending_results.size(), typed ? res : r);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    @(posedge clk_i);
  endtask

  function automatic void cmp_field(string fname, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, fname, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result word 0x%0h", $time, out_word_o);
        err_cnt++;
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        cmp_field("granted", want.granted, out_word_o.granted);
        cmp_field("out_task_id", want.out_task_id, out_word_o.out_task_id);
        cmp_field("out_service_total", want.out_service_total, out_word_o.out_service_total);
        cmp_field("out_service_done", want.out_service_done, out_word_o.out_service_done);
        cmp_field("keep_running", want.keep_running, out_word_o.keep_running);
        cmp_field("run_level", want.run_level, out_word_o.run_level);
        cmp_field("queue_error", want.queue_error, out_word_o.queue_error);
        cmp_field("none_waiting", want.none_waiting, out_word_o.none_waiting);
      end
    end
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_ack) begin
        hold_ack = hold_req;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    int unsigned cfg_plan[7];
    cfg_plan = '{7, 0, 1, 5, 2, 6, 3};

    add_row(mk_word(OP_CHECK, 0, 8'h05, 16'd10, 0, 0), 1,
            mk_res(0, 0, 0, 0, 0, 0, 0, 1));
    add_row(mk_word(OP_SELECT, 0, 0, 1, 0, 0), 1,
            mk_res(0, 0, 0, 0, 0, 0, 0, 1));
    add_row(mk_word(OP_NOP, 1, 8'hff, 16'hffff, 16'hffff, 16'hffff), 1,
            mk_res(0, 0, 0, 0, 0, 0, 0, 1));
    add_row(mk_word(OP_INSERT, 0, 8'hff, 16'hffff, 16'hffff, 0), 1,
            mk_res(1, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk_word(OP_INSERT, 1, 8'h00, 16'h0001, 0, 16'hffff), 1,
            mk_res(1, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk_word(OP_SELECT, 0, 0, 1, 0, 0), 1,
            mk_res(1, 8'hff, 16'hffff, 16'hffff, 0, 0, 0, 0));
    add_row(mk_word(OP_CHECK, 0, 8'hff, 16'hffff, 16'hffff, 16'hffff), 1,
            mk_res(0, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk_word(OP_CHECK, 0, 8'hff, 16'hffff, 0, 0), 0, '0);
    add_row(mk_word(OP_CHECK, 0, 8'hff, 16'hffff, 0, 1), 0, '0);
    add_row(mk_word(OP_INSERT, 0, 8'hff, 16'hffff, 1, 0), 0, '0);
    add_row(mk_word(OP_SELECT, 0, 0, 1, 0, 0), 0, '0);
    add_row(mk_word(OP_SELECT, 0, 0, 1, 0, 0), 0, '0);
    add_row(mk_word(OP_CHECK, 0, 8'hff, 16'hffff, 1, 1), 0, '0);
    add_row(mk_word(OP_CHECK, 0, 8'hff, 16'hffff, 1, 2), 0, '0);
    add_row(mk_word(OP_INSERT, 0, 8'hff, 16'hffff, 3, 0), 0, '0);
    add_row(mk_word(OP_SELECT, 0, 0, 1, 0, 0), 0, '0);
    add_row(mk_word(OP_INSERT, 0, 8'haa, 16'h1234, 0, 0), 0, '0);
    add_row(mk_word(OP_SELECT, 0, 0, 1, 0, 0), 0, '0);
    add_row(mk_word(OP_CHECK, 0, 8'haa, 16'hffff, 0, 16'hfffe), 0, '0);
    add_row(mk_word(OP_INSERT, 0, 8'haa, 16'h1234, 0, 0), 1,
            mk_res(0, 0, 0, 0, 0, 3, 1, 1));
    add_row(mk_word(OP_SELECT, 0, 0, 1, 0, 0), 1,
            mk_res(0, 0, 0, 0, 0, 3, 0, 1));
    add_row(mk_word(OP_CHECK, 0, 8'haa, 16'h0001, 0, 0), 0, '0);
    add_row(mk_word(OP_CHECK, 0, 8'haa, 16'h0001, 1, 0), 0, '0);
    add_row(mk_word(OP_INSERT, 1, 8'h55, 16'h8000, 16'h7fff, 0), 1,
            mk_res(1, 0, 0, 0, 0, 3, 0, 0));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) push_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].res);

    for (int p = 0; p < 7; p++) begin
      drain_results();
      cfg_valid <= 1'b1;
      cfg_data  <= NUM_LEVELS_W'(cfg_plan[p]);
      do @(posedge clk_i); while (!cfg_ready_o);
      lv_cfg = NUM_LEVELS_W'(cfg_plan[p]);
      cfg_valid <= 1'b0;
      send_idle_pct  = (p < 2) ? 10 : (p < 4) ? 66 : 0;
      recv_stall_pct = (p < 2) ? 66 : (p < 4) ? 10 : 0;
      for (int n = 0; n < 255; n++) begin
        if (p == 1 && n == 80) hold_req++;
        if (p == 4 && n == 60) hold_req++;
        if (p == 3 && n == 120) drain_results();
        push_word(next_sched_word(), 1'b0, '0);
      end
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
